// File: rtl/tcsb_pkg.sv
// Shared types and constants for the text console scroll buffer.
// Depends on nothing; every other file of the block takes names from here.
package tcsb_pkg;

	typedef logic [7:0] char_t;
	typedef logic [5:0] line_t;
	typedef logic [6:0] column_t;
	typedef logic [1:0] cfg_index_t;
	typedef logic [7:0] cfg_data_t;

	typedef enum logic {
		KIND_PUT  = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	// Request transaction
	typedef struct packed {
		kind_t         kind;
		char_t         char_in;
		logic [5:0]    display_row;
		logic [6:0]    display_col;
	} req_t;

	// Response transaction
	typedef struct packed {
		char_t   cell_char;
		line_t   cursor_line;
		column_t cursor_column;
	} rsp_t;

	// Register indexes of the configuration channel
	localparam cfg_index_t REG_COLUMNS = 2'd0;
	localparam cfg_index_t REG_ROWS    = 2'd1;

	localparam int COLUMNS_RST = 80;
	localparam int ROWS_RST    = 25;

	localparam char_t NEWLINE_CHAR = 8'h0A;
	localparam char_t SPACE_CHAR   = 8'h20;

	// Index width for a count of n entries, at least one bit
	function automatic int idx_width(input int n);
		idx_width = (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// File: rtl/text_console_scroll_buffer.sv
// Top level of the text console scroll buffer: sequencer plus cell memory.
// Depends on tcsb_pkg, tcsb_ctrl and tcsb_cell_ram.
//
//   channel | signals                                | direction
//   req     | req_valid, req_ready, req              | in
//   rsp     | rsp_valid, rsp_ready, rsp              | out
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// A read passes through the states S_EXEC, S_RDATA and S_DONE, a put through S_EXEC and
// S_DONE, which loads the response register and then returns to idle.
// A put that starts a new line also passes through S_CLEAR: the line is blanked one
// cell per cycle through the single memory write port.
// After reset a sweep blanks all MAX_ROWS * 2**ceil(log2(MAX_COLUMNS)) cells of the
// memory (8192 at the defaults); req_ready stays low, cfg writes are taken.
// One transaction is in flight at a time; the next is accepted while a response
// waits in the output register, and its result loads once that register frees.
module text_console_scroll_buffer #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  tcsb_pkg::req_t         req,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output tcsb_pkg::rsp_t         rsp,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  tcsb_pkg::cfg_index_t   cfg_index,
	input  tcsb_pkg::cfg_data_t    cfg_data
);

	localparam int CW     = tcsb_pkg::idx_width(MAX_COLUMNS);
	localparam int RW     = tcsb_pkg::idx_width(MAX_ROWS);
	localparam int ADDR_W = RW + CW;
	localparam int DEPTH  = MAX_ROWS * (2 ** CW);

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	tcsb_pkg::char_t     mem_wdata;
	logic [ADDR_W-1:0]   mem_raddr;
	tcsb_pkg::char_t     mem_rdata;

	tcsb_ctrl #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.ADDR_W      (ADDR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	tcsb_cell_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// File: rtl/tcsb_cell_ram.sv
// Character cell memory: one write port, one read port, registered read data.
// Depends on tcsb_pkg for the cell type.
module tcsb_cell_ram #(
	parameter int DEPTH  = 8192,
	parameter int ADDR_W = 13
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  tcsb_pkg::char_t     wdata,
	input  logic [ADDR_W-1:0]   raddr,
	output tcsb_pkg::char_t     rdata
);

	tcsb_pkg::char_t mem [DEPTH];

	// Write one cell
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one cell, data valid the next cycle
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/tcsb_ctrl.sv
// Sequencer of the scroll buffer: cursor, configuration, line clears, reset sweep
// and the response register. Drives the cell memory; depends on tcsb_pkg.
module tcsb_ctrl #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 64,
	parameter int ADDR_W      = 13
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  tcsb_pkg::req_t         req,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output tcsb_pkg::rsp_t         rsp,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  tcsb_pkg::cfg_index_t   cfg_index,
	input  tcsb_pkg::cfg_data_t    cfg_data,
	output logic                   mem_we,
	output logic [ADDR_W-1:0]      mem_waddr,
	output tcsb_pkg::char_t        mem_wdata,
	output logic [ADDR_W-1:0]      mem_raddr,
	input  tcsb_pkg::char_t        mem_rdata
);

	localparam int CW    = tcsb_pkg::idx_width(MAX_COLUMNS);
	localparam int RW    = tcsb_pkg::idx_width(MAX_ROWS);
	localparam int CN_W  = CW + 1;
	localparam int RN_W  = RW + 1;
	localparam int DEPTH = MAX_ROWS * (2 ** CW);
	localparam int RST_COLS = (tcsb_pkg::COLUMNS_RST > MAX_COLUMNS) ?
		MAX_COLUMNS : tcsb_pkg::COLUMNS_RST;
	localparam int RST_ROWS = (tcsb_pkg::ROWS_RST > MAX_ROWS) ?
		MAX_ROWS : tcsb_pkg::ROWS_RST;
	localparam logic [ADDR_W-1:0] INIT_LAST = ADDR_W'(DEPTH - 1);
	localparam logic [CW-1:0]     CLR_LAST  = CW'(MAX_COLUMNS - 1);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_CLEAR,
		S_RDATA,
		S_DONE
	} state_t;

	state_t              state_q;
	tcsb_pkg::req_t      item_q;
	logic [RW-1:0]       cur_line_q;
	logic [CW-1:0]       cur_col_q;
	logic [CN_W-1:0]     cols_q;
	logic [RN_W-1:0]     rows_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic                space_q;
	tcsb_pkg::char_t     cell_q;
	logic                rsp_valid_q;
	tcsb_pkg::rsp_t      rsp_q;

	logic [CN_W-1:0]     cols_wr;
	logic [RN_W-1:0]     rows_wr;
	logic                is_newline;
	logic [CN_W-1:0]     col_inc;
	logic [CW-1:0]       col_next;
	logic [RN_W-1:0]     line_inc;
	logic [RW-1:0]       line_next;
	logic                advance;
	logic                in_range;
	logic [RN_W-1:0]     rd_sum;
	logic [RN_W-1:0]     rd_line;

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Saturate register writes to the supported range, zero to one; rows use data bits 6:0
	always_comb begin
		if (cfg_data == '0) begin
			cols_wr = CN_W'(1);
		end else if (int'(cfg_data) > MAX_COLUMNS) begin
			cols_wr = CN_W'(MAX_COLUMNS);
		end else begin
			cols_wr = CN_W'(cfg_data);
		end
		if (cfg_data[6:0] == '0) begin
			rows_wr = RN_W'(1);
		end else if (int'(cfg_data[6:0]) > MAX_ROWS) begin
			rows_wr = RN_W'(MAX_ROWS);
		end else begin
			rows_wr = RN_W'(cfg_data[6:0]);
		end
	end

	// Advance the cursor for a put
	always_comb begin
		is_newline = (item_q.char_in == tcsb_pkg::NEWLINE_CHAR);
		col_inc    = CN_W'(cur_col_q) + CN_W'(1);
		if (is_newline || col_inc == cols_q) begin
			col_next = '0;
		end else begin
			col_next = col_inc[CW-1:0];
		end
		advance  = (col_next == '0);
		line_inc = RN_W'(cur_line_q) + RN_W'(1);
		if (line_inc == rows_q) begin
			line_next = '0;
		end else begin
			line_next = line_inc[RW-1:0];
		end
	end

	// Map the display row to a stored line; for an in-range row the sum stays below twice rows
	always_comb begin
		in_range = (int'(item_q.display_row) < int'(rows_q)) &&
			(int'(item_q.display_col) < int'(cols_q));
		rd_sum = RN_W'(item_q.display_row) + RN_W'(cur_line_q) + RN_W'(1);
		if (rd_sum >= rows_q) begin
			rd_line = rd_sum - rows_q;
		end else begin
			rd_line = rd_sum;
		end
		mem_raddr = {rd_line[RW-1:0], CW'(item_q.display_col)};
	end

	// Select the memory write for the reset sweep, a put or a line clear
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {cur_line_q, cur_col_q};
		mem_wdata = tcsb_pkg::SPACE_CHAR;
		case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
			end
			S_EXEC: begin
				mem_we    = (item_q.kind == tcsb_pkg::KIND_PUT) && !is_newline;
				mem_wdata = item_q.char_in;
			end
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = {cur_line_q, cnt_q[CW-1:0]};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Sequence each transaction and hold the response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			item_q      <= '0;
			cur_line_q  <= '0;
			cur_col_q   <= '0;
			cols_q      <= CN_W'(RST_COLS);
			rows_q      <= RN_W'(RST_ROWS);
			cnt_q       <= '0;
			space_q     <= 1'b0;
			cell_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == INIT_LAST) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						item_q  <= req;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (item_q.kind == tcsb_pkg::KIND_PUT) begin
						cell_q    <= '0;
						cur_col_q <= col_next;
						if (advance) begin
							cur_line_q <= line_next;
							cnt_q      <= '0;
							state_q    <= S_CLEAR;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						space_q <= !in_range;
						state_q <= S_RDATA;
					end
				end
				S_CLEAR: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q[CW-1:0] == CLR_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_RDATA: begin
					cell_q  <= space_q ? tcsb_pkg::SPACE_CHAR : mem_rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q         <= 1'b1;
						rsp_q.cell_char     <= cell_q;
						rsp_q.cursor_line   <= tcsb_pkg::line_t'(cur_line_q);
						rsp_q.cursor_column <= tcsb_pkg::column_t'(cur_col_q);
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// Register writes must arrive only while idle; the user keeps to this, the block does not enforce it
			if (cfg_valid) begin
				case (cfg_index)
					tcsb_pkg::REG_COLUMNS: begin
						cols_q <= cols_wr;
						if (CN_W'(cur_col_q) >= cols_wr) begin
							cur_col_q <= '0;
						end
					end
					tcsb_pkg::REG_ROWS: begin
						rows_q <= rows_wr;
						if (RN_W'(cur_line_q) >= rows_wr) begin
							cur_line_q <= '0;
						end
					end
					default: begin
						cols_q <= cols_q;
					end
				endcase
			end
		end
	end

endmodule

// File: rtl/tcsb_checker.sv
// Port-level checks for the scroll buffer, bound to the top level.
// Depends on tcsb_pkg and text_console_scroll_buffer.
module tcsb_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input tcsb_pkg::req_t         req,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input tcsb_pkg::rsp_t         rsp,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input tcsb_pkg::cfg_index_t   cfg_index,
	input tcsb_pkg::cfg_data_t    cfg_data
);

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Drop ready after a request transaction: one item in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// A response cannot appear in the cycle right after acceptance
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("response raised too early");

	// Configuration channel never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration transaction stalled");

endmodule

bind text_console_scroll_buffer tcsb_checker u_tcsb_checker (.*);

// File: tb/tcsb_grid_checker.sv
// Checker for the text console scroll buffer: keeps its own copy of the grid,
// predicts every response and compares it with what the block returns.
// Depends on tcsb_pkg for the transaction types and the character constants.
module tcsb_grid_checker #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_ready,
	input  tcsb_pkg::req_t       req,
	input  logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  tcsb_pkg::rsp_t       rsp,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  tcsb_pkg::cfg_index_t cfg_index,
	input  tcsb_pkg::cfg_data_t  cfg_data,
	output int                   errors,
	output int                   pending
);

	// Shadow of the console grid and its cursor
	tcsb_pkg::char_t console_cells [MAX_ROWS][MAX_COLUMNS];
	int    cur_line;
	int    cur_col;
	int    width_in_use;
	int    height_in_use;
	int    mismatches;

	// Responses the block still owes, oldest first
	tcsb_pkg::rsp_t  owed_cells[$];

	function automatic int saturate(input int v, input int hi);
		if (v < 1) begin
			return 1;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	function automatic void blank_row(input int line);
		for (int c = 0; c < MAX_COLUMNS; c++) begin
			console_cells[line][c] = tcsb_pkg::SPACE_CHAR;
		end
	endfunction

	// Apply a register write; pull the cursor home if it falls outside
	function automatic void take_register(input tcsb_pkg::cfg_index_t idx,
			input tcsb_pkg::cfg_data_t data);
		case (idx)
			tcsb_pkg::REG_COLUMNS: begin
				width_in_use = saturate(int'(data), MAX_COLUMNS);
				if (cur_col >= width_in_use) begin
					cur_col = 0;
				end
			end
			tcsb_pkg::REG_ROWS: begin
				height_in_use = saturate(int'(data & 8'h7F), MAX_ROWS);
				if (cur_line >= height_in_use) begin
					cur_line = 0;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Advance the shadow grid by one transaction and return the response it owes
	function automatic tcsb_pkg::rsp_t advance_console(input tcsb_pkg::req_t item);
		tcsb_pkg::rsp_t r;
		int   line;
		r.cell_char = 8'h00;
		if (item.kind == tcsb_pkg::KIND_PUT) begin
			if (item.char_in == tcsb_pkg::NEWLINE_CHAR) begin
				cur_col = 0;
			end else begin
				console_cells[cur_line][cur_col] = item.char_in;
				cur_col = (cur_col + 1) % width_in_use;
			end
			// scroll on every return to column zero, newline at column zero included
			if (cur_col == 0) begin
				cur_line = (cur_line + 1) % height_in_use;
				blank_row(cur_line);
			end
		end else if (int'(item.display_row) < height_in_use &&
				int'(item.display_col) < width_in_use) begin
			line = (int'(item.display_row) + cur_line + 1) % height_in_use;
			r.cell_char = console_cells[line][item.display_col];
		end else begin
			r.cell_char = tcsb_pkg::SPACE_CHAR;
		end
		r.cursor_line   = tcsb_pkg::line_t'(cur_line);
		r.cursor_column = tcsb_pkg::column_t'(cur_col);
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// Watch all three channels; compare first, then queue the new prediction
	always @(posedge clk or negedge arst_n) begin
		tcsb_pkg::rsp_t want;
		if (!arst_n) begin
			for (int l = 0; l < MAX_ROWS; l++) begin
				blank_row(l);
			end
			cur_line      = 0;
			cur_col       = 0;
			width_in_use  = saturate(tcsb_pkg::COLUMNS_RST, MAX_COLUMNS);
			height_in_use = saturate(tcsb_pkg::ROWS_RST, MAX_ROWS);
			mismatches    = 0;
			owed_cells.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				take_register(cfg_index, cfg_data);
			end
			if (rsp_valid && rsp_ready) begin
				if (owed_cells.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected transaction, expected none, actual %h %h %h",
						$time, rsp.cell_char, rsp.cursor_line, rsp.cursor_column);
				end else begin
					want = owed_cells.pop_front();
					check_field("cell_char", 32'(want.cell_char), 32'(rsp.cell_char));
					check_field("cursor_line", 32'(want.cursor_line),
						32'(rsp.cursor_line));
					check_field("cursor_column", 32'(want.cursor_column),
						32'(rsp.cursor_column));
				end
			end
			if (req_valid && req_ready) begin
				owed_cells.push_back(advance_console(req));
			end
			errors  <= mismatches;
			pending <= owed_cells.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Top of the scroll buffer testbench: clock, reset, stimulus and the verdict.
// Depends on tcsb_pkg, the block text_console_scroll_buffer and tcsb_grid_checker.
module tb_top;

	localparam int MAX_COLUMNS      = 128;
	localparam int MAX_ROWS         = 64;
	localparam int PHASES           = 10;
	localparam int RANDOM_PER_PHASE = 150;
	localparam int SETTLE_CYCLES    = MAX_COLUMNS + 16;
	localparam int HOLD_AT          = 230;
	localparam int HOLD_CYCLES      = 500;
	localparam int CYCLE_LIMIT      = 1500000;
	localparam tcsb_pkg::cfg_index_t REG_SPARE = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	tcsb_pkg::req_t       req;
	logic                 rsp_valid;
	logic                 rsp_ready;
	tcsb_pkg::rsp_t       rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	tcsb_pkg::cfg_index_t cfg_index;
	tcsb_pkg::cfg_data_t  cfg_data;
	int                   chk_errors;
	int                   chk_pending;

	// Geometry in use, only to aim reads at live cells
	int cols_now;
	int rows_now;
	int burst_left;

	// Register plans for phases 1 and up; -1 picks a random legal value
	int width_plan  [PHASES-1] = '{1, 128, 0, 255, 3, 200, 17, -1, 40};
	int height_plan [PHASES-1] = '{1, 64, 0, 127, 4, 200, 5, -1, 10};

	text_console_scroll_buffer #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	tcsb_grid_checker #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) grid_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (chk_errors),
		.pending  (chk_pending)
	);

	// Clock: 10 time units
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Guard against a hung block
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	// Receiver: stall on a changing duty pattern, with one long hold-off
	initial begin
		int  seen;
		int  pct;
		int  mode_left;
		bit  held;
		seen      = 0;
		pct       = 100;
		mode_left = 0;
		held      = 1'b0;
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				seen++;
			end
			if (!held && seen >= HOLD_AT) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				case ($urandom_range(0, 3))
					0: pct = 100;
					1: pct = 75;
					2: pct = 40;
					default: pct = 10;
				endcase
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			rsp_ready <= ($urandom_range(1, 100) <= pct);
		end
	end

	function automatic tcsb_pkg::req_t make_req(input tcsb_pkg::kind_t k,
			input tcsb_pkg::char_t c, input int r, input int col);
		tcsb_pkg::req_t item;
		item.kind        = k;
		item.char_in     = c;
		item.display_row = 6'(r);
		item.display_col = 7'(col);
		return item;
	endfunction

	// Mostly text with some newlines, reads mostly aimed inside the grid
	function automatic tcsb_pkg::req_t random_req();
		tcsb_pkg::req_t item;
		int   pick;
		item.char_in     = 8'($urandom);
		item.display_row = 6'($urandom);
		item.display_col = 7'($urandom);
		if ($urandom_range(0, 99) < 60) begin
			item.kind = tcsb_pkg::KIND_PUT;
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				item.char_in = tcsb_pkg::NEWLINE_CHAR;
			end else if (pick < 60) begin
				item.char_in = 8'($urandom_range(8'h21, 8'h7E));
			end
		end else begin
			item.kind = tcsb_pkg::KIND_READ;
			if ($urandom_range(0, 99) < 75) begin
				item.display_row = 6'($urandom_range(0, rows_now - 1));
				item.display_col = 7'($urandom_range(0, cols_now - 1));
			end
		end
		return item;
	endfunction

	// Offer one transaction, hold it until taken, then maybe open a gap
	task automatic push_req(input tcsb_pkg::req_t item);
		int gap;
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 15);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 30);
		end
	endtask

	task automatic write_reg(input tcsb_pkg::cfg_index_t idx, input int value);
		cfg_index <= idx;
		cfg_data  <= tcsb_pkg::cfg_data_t'(value);
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Wait until every response is in, then let a line clear finish
	task automatic settle();
		do @(posedge clk); while (chk_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stimulus and verdict
	initial begin
		int w;
		int h;
		arst_n     <= 1'b0;
		req_valid  <= 1'b0;
		req        <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= tcsb_pkg::REG_COLUMNS;
		cfg_data   <= '0;
		burst_left = 0;
		cols_now   = tcsb_pkg::COLUMNS_RST;
		rows_now   = tcsb_pkg::ROWS_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: corners of a blank grid at the reset geometry, then reads outside it
		push_req(make_req(tcsb_pkg::KIND_READ, 8'hFF, 0, 0));
		push_req(make_req(tcsb_pkg::KIND_READ, 8'h00, tcsb_pkg::ROWS_RST - 1,
			tcsb_pkg::COLUMNS_RST - 1));
		push_req(make_req(tcsb_pkg::KIND_READ, 8'h00, tcsb_pkg::ROWS_RST, 0));
		push_req(make_req(tcsb_pkg::KIND_READ, 8'h00, 0, tcsb_pkg::COLUMNS_RST));
		push_req(make_req(tcsb_pkg::KIND_READ, 8'h55, 63, 127));
		// extreme and alternating bytes, then newline mid-line and at column zero
		push_req(make_req(tcsb_pkg::KIND_PUT, 8'h00, 63, 127));
		push_req(make_req(tcsb_pkg::KIND_PUT, 8'hFF, 0, 0));
		push_req(make_req(tcsb_pkg::KIND_PUT, 8'h55, 42, 85));
		push_req(make_req(tcsb_pkg::KIND_PUT, 8'hAA, 21, 42));
		push_req(make_req(tcsb_pkg::KIND_PUT, tcsb_pkg::NEWLINE_CHAR, 0, 0));
		push_req(make_req(tcsb_pkg::KIND_PUT, tcsb_pkg::NEWLINE_CHAR, 63, 127));
		push_req(make_req(tcsb_pkg::KIND_PUT, 8'h41, 0, 0));
		// read back the written line, the blank one and the current one
		push_req(make_req(tcsb_pkg::KIND_READ, 8'h00, tcsb_pkg::ROWS_RST - 3, 0));
		push_req(make_req(tcsb_pkg::KIND_READ, 8'hFF, tcsb_pkg::ROWS_RST - 3, 1));
		push_req(make_req(tcsb_pkg::KIND_READ, 8'h00, tcsb_pkg::ROWS_RST - 3, 2));
		push_req(make_req(tcsb_pkg::KIND_READ, 8'h00, tcsb_pkg::ROWS_RST - 3, 3));
		push_req(make_req(tcsb_pkg::KIND_READ, 8'h00, tcsb_pkg::ROWS_RST - 3, 4));
		push_req(make_req(tcsb_pkg::KIND_READ, 8'h00, tcsb_pkg::ROWS_RST - 2, 0));
		push_req(make_req(tcsb_pkg::KIND_READ, 8'h00, tcsb_pkg::ROWS_RST - 1, 0));
		push_req(make_req(tcsb_pkg::KIND_READ, 8'h00, tcsb_pkg::ROWS_RST - 1, 1));

		// Random phases, each under its own geometry
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				settle();
				w = width_plan[ph - 1];
				h = height_plan[ph - 1];
				if (w < 0) begin
					w = $urandom_range(1, MAX_COLUMNS);
				end
				if (h < 0) begin
					h = $urandom_range(1, MAX_ROWS);
				end
				write_reg(tcsb_pkg::REG_COLUMNS, w);
				write_reg(tcsb_pkg::REG_ROWS, h);
				if (ph == 5) begin
					write_reg(REG_SPARE, $urandom_range(0, 255));
				end
				cfg_valid <= 1'b0;
				w = w & 8'hFF;
				h = h & 8'h7F;
				cols_now = (w < 1) ? 1 : ((w > MAX_COLUMNS) ? MAX_COLUMNS : w);
				rows_now = (h < 1) ? 1 : ((h > MAX_ROWS) ? MAX_ROWS : h);
			end
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				push_req(random_req());
			end
			req_valid <= 1'b0;
		end

		settle();
		if (chk_errors == 0 && chk_pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
